[design/ect_pkg.sv]
// ect_pkg: shared constants, types and a helper function for the endpoint channel table
// depends on nothing
package ect_pkg;

	localparam int NUM_PES            = 8;
	localparam int EPS_PER_PE         = 16;
	localparam int CHANNELS_PER_GROUP = 16;
	localparam int DATAPORT_BYTES     = 4096;
	localparam int RING_CTRL_BYTES    = 64;

	localparam int NUM_EPS   = NUM_PES * EPS_PER_PE;
	localparam int NUM_CHANS = 2 * CHANNELS_PER_GROUP;
	localparam int PE_W      = $clog2(NUM_PES);
	localparam int EPI_W     = (EPS_PER_PE > 1) ? $clog2(EPS_PER_PE) : 1;
	localparam int SLOT_W    = $clog2(NUM_EPS);
	localparam int CH_W      = $clog2(NUM_CHANS);
	localparam int GRP_W     = (CHANNELS_PER_GROUP > 1) ? $clog2(CHANNELS_PER_GROUP) : 1;
	localparam int UPPER_PE  = 3;
	localparam int ROOM      = (DATAPORT_BYTES > RING_CTRL_BYTES) ?
		(DATAPORT_BYTES - RING_CTRL_BYTES) : 0;

	localparam logic [3:0] F_RECV     = 4'd0;
	localparam logic [3:0] F_RECV_AT  = 4'd1;
	localparam logic [3:0] F_SEND     = 4'd2;
	localparam logic [3:0] F_MEM      = 4'd3;
	localparam logic [3:0] F_INVAL    = 4'd4;
	localparam logic [3:0] F_TERM     = 4'd5;
	localparam logic [3:0] F_INV_FROM = 4'd6;
	localparam logic [3:0] F_SET_ID   = 4'd7;
	localparam logic [3:0] F_SET_PRIV = 4'd8;
	localparam logic [3:0] F_WAKE     = 4'd9;

	localparam logic [1:0] T_INVALID = 2'd0;
	localparam logic [1:0] T_SEND    = 2'd1;
	localparam logic [1:0] T_RECV    = 2'd2;
	localparam logic [1:0] T_MEM     = 2'd3;

	localparam logic [2:0] S_OK      = 3'd0;
	localparam logic [2:0] S_BAD     = 3'd1;
	localparam logic [2:0] S_CONF    = 3'd2;
	localparam logic [2:0] S_NOFREE  = 3'd3;
	localparam logic [2:0] S_INUSE   = 3'd4;
	localparam logic [2:0] S_NOTRECV = 3'd5;
	localparam logic [2:0] S_NOTCONF = 3'd6;
	localparam logic [2:0] S_WAKE    = 3'd7;

	// classified command passed from front to back
	typedef struct packed {
		logic [3:0]        func;
		logic              bad;
		logic [PE_W-1:0]   pe;
		logic [EPI_W-1:0]  ep;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] dslot;
		logic [4:0]        didx;
		logic [2:0]        dpe;
		logic [15:0]       dvpe;
		logic [15:0]       sa;
		logic [15:0]       sb;
		logic [7:0]        mode;
		logic [63:0]       wa;
		logic [63:0]       wb;
		logic [31:0]       cnt;
		logic [31:0]       sz;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  chan;
		logic [31:0] cnt;
		logic [31:0] sz;
		logic [1:0]  wake;
	} res_t;

	// largest power of two not above lim, at least 2
	function automatic logic [31:0] pow2_floor(input logic [31:0] lim);
		logic [31:0] p;
		p = 32'd2;
		for (int i = 31; i >= 1; i--) begin
			if (lim[i] && p == 32'd2) p = 32'd1 << i;
		end
		return p;
	endfunction

endpackage

[design/ect_front.sv]
// ect_front: accepts commands, checks ranges and works out receive ring geometry
// depends on ect_pkg
module ect_front import ect_pkg::*; (
	input  logic        in_valid,
	input  logic [3:0]  func,
	input  logic [2:0]  pe_sel,
	input  logic [3:0]  ep_index,
	input  logic [2:0]  dest_pe,
	input  logic [4:0]  dest_index,
	input  logic [15:0] dst_vpe_id,
	input  logic [15:0] size_a,
	input  logic [15:0] size_b,
	input  logic [7:0]  mode_bits,
	input  logic [63:0] wide_a,
	input  logic [63:0] wide_b,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_data
);

	logic pe_ok, ep_ok, dpe_ok, didx_ok;
	logic [4:0] mo, bo;
	logic [31:0] size_v, count_v, lim_v;
	logic [63:0] need_v;

	assign q_push = in_valid && !q_full;

	always_comb begin
		pe_ok   = 32'(pe_sel) < NUM_PES;
		ep_ok   = pe_ok && (32'(ep_index) < EPS_PER_PE);
		dpe_ok  = 32'(dest_pe) < NUM_PES;
		didx_ok = 32'(dest_index) < EPS_PER_PE;
		bo = size_a[4:0];
		mo = size_b[4:0];
		size_v  = 32'd1 << mo;
		count_v = 32'd1 << (bo - mo);
		need_v  = 64'(RING_CTRL_BYTES) + (64'(count_v) << mo);
		lim_v   = 32'(ROOM) >> mo;
		q_data = '0;
		q_data.func = func;
		q_data.pe   = pe_sel[PE_W-1:0];
		q_data.ep   = ep_index[EPI_W-1:0];
		q_data.slot = ep_ok ? SLOT_W'(32'(pe_sel) * EPS_PER_PE + 32'(ep_index)) : '0;
		q_data.dslot = SLOT_W'(32'(dest_pe) * EPS_PER_PE + 32'(dest_index));
		q_data.didx = dest_index;
		q_data.dpe  = dest_pe;
		q_data.dvpe = dst_vpe_id;
		q_data.sa   = size_a;
		q_data.sb   = size_b;
		q_data.mode = mode_bits;
		q_data.wa   = wide_a;
		q_data.wb   = wide_b;
		q_data.sz   = size_v;
		q_data.cnt  = (need_v > 64'(DATAPORT_BYTES)) ? pow2_floor(lim_v) : count_v;
		unique case (func)
			F_RECV, F_RECV_AT: q_data.bad = !ep_ok || size_a > 16'd31 || size_b > 16'd31
				|| size_b > size_a || (func == F_RECV_AT && 32'(dest_index) >= NUM_CHANS);
			F_SEND: q_data.bad = !ep_ok || !dpe_ok || !didx_ok;
			F_MEM, F_INVAL, F_TERM, F_INV_FROM: q_data.bad = !ep_ok;
			F_SET_ID, F_SET_PRIV, F_WAKE: q_data.bad = !pe_ok;
			default: q_data.bad = 1'b1;
		endcase
	end

endmodule

[design/ect_queue.sv]
// ect_queue: two-entry queue between front and back
// depends on ect_pkg
module ect_queue import ect_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

[design/ect_back.sv]
// ect_back: endpoint table, channel pool and per-element registers; executes commands
// depends on ect_pkg
module ect_back import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        cmd,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] type_q [NUM_EPS];
	logic [CH_W-1:0] chan_mem [NUM_EPS];
	logic [63:0] small_mem [NUM_EPS];
	logic [63:0] wa_mem [NUM_EPS];
	logic [63:0] wb_mem [NUM_EPS];
	logic [NUM_CHANS-1:0] in_use_q;
	logic [6:0] owner_mem [NUM_CHANS];
	logic [15:0] vpe_q [NUM_PES];
	logic [7:0] priv_q [NUM_PES];
	logic [CH_W-1:0] rd_chan_q, rd_dchan_q;
	logic [1:0] rd_type_q, rd_dtype_q;
	logic [EPI_W:0] walk_q;
	logic walk_ph_q;
	logic [SLOT_W-1:0] wslot;
	logic [GRP_W-1:0] free_idx;
	logic free_found;
	logic [CH_W-1:0] free_ch;
	logic [CH_W-1:0] claim_ch;
	logic walk_done, exec_fire, walk_fire, load_res;
	res_t res_n;
	logic type_we;
	logic [1:0] type_wd;
	logic use_we, use_set;
	logic [CH_W-1:0] use_ch;

	assign wslot = SLOT_W'(32'(cmd.pe) * EPS_PER_PE + 32'(walk_q));
	assign walk_done = 32'(walk_q) >= EPS_PER_PE;

	// a result can be loaded when the output register is free or being taken
	assign exec_fire = state_q == ST_EXEC && !(out_valid && out_stall);
	assign walk_fire = state_q == ST_WALK && walk_done && !(out_valid && out_stall);
	assign load_res  = exec_fire || walk_fire;
	assign q_pop     = load_res;

	// lowest free channel in the element's group
	always_comb begin
		logic [CHANNELS_PER_GROUP-1:0] grp;
		grp = (32'(cmd.pe) == UPPER_PE) ? in_use_q[NUM_CHANS-1 -: CHANNELS_PER_GROUP]
			: in_use_q[CHANNELS_PER_GROUP-1:0];
		free_found = 1'b0;
		free_idx = '0;
		for (int i = CHANNELS_PER_GROUP-1; i >= 0; i--) begin
			if (!grp[i]) begin
				free_found = 1'b1;
				free_idx = GRP_W'(i);
			end
		end
		free_ch = CH_W'(32'(free_idx) + ((32'(cmd.pe) == UPPER_PE) ? CHANNELS_PER_GROUP : 0));
	end

	// result and table updates of the command at the head
	always_comb begin
		res_n = '0;
		type_we = 1'b0;
		type_wd = T_INVALID;
		use_we = 1'b0;
		use_set = 1'b0;
		use_ch = '0;
		claim_ch = (cmd.func == F_RECV_AT) ? cmd.didx : free_ch;
		if (cmd.bad) begin
			res_n.status = S_BAD;
		end else begin
			unique case (cmd.func)
				F_RECV, F_RECV_AT: begin
					priority if (cmd.func == F_RECV_AT && in_use_q[cmd.didx])
						res_n.status = S_INUSE;
					else if (rd_type_q != T_INVALID) res_n.status = S_CONF;
					else if (cmd.func == F_RECV && !free_found) res_n.status = S_NOFREE;
					else begin
						type_we = 1'b1;
						type_wd = T_RECV;
						use_we = 1'b1;
						use_set = 1'b1;
						use_ch = claim_ch;
						res_n.chan = claim_ch;
						res_n.cnt = cmd.cnt;
						res_n.sz = cmd.sz;
					end
				end
				F_SEND: if (rd_dtype_q != T_RECV) res_n.status = S_NOTRECV;
					else begin
						type_we = 1'b1;
						type_wd = T_SEND;
						res_n.chan = rd_dchan_q;
					end
				F_MEM: priority if (rd_type_q != T_INVALID) res_n.status = S_CONF;
					else if (!free_found) res_n.status = S_NOFREE;
					else begin
						type_we = 1'b1;
						type_wd = T_MEM;
						use_we = 1'b1;
						use_set = 1'b1;
						use_ch = claim_ch;
						res_n.chan = claim_ch;
					end
				F_INVAL: begin
					type_we = 1'b1;
					type_wd = T_INVALID;
					if (rd_type_q == T_RECV || rd_type_q == T_MEM) begin
						use_we = 1'b1;
						use_ch = rd_chan_q;
					end
				end
				F_TERM: if (rd_type_q == T_INVALID) res_n.status = S_NOTCONF;
					else res_n.chan = rd_chan_q;
				F_INV_FROM, F_SET_ID, F_SET_PRIV: ;
				F_WAKE: priority if (cmd.pe == PE_W'(0)) res_n.wake = 2'd1;
					else if (cmd.pe == PE_W'(1)) res_n.wake = 2'd2;
					else if (32'(cmd.pe) == UPPER_PE) res_n.wake = 2'd3;
					else res_n.status = S_WAKE;
				default: res_n.status = S_BAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_chan_q  <= chan_mem[(state_q == ST_WALK) ? wslot : cmd.slot];
		rd_dchan_q <= chan_mem[cmd.dslot];
		if (exec_fire && type_we) begin
			unique case (type_wd)
				T_RECV: begin
					chan_mem[cmd.slot] <= claim_ch;
					small_mem[cmd.slot] <= 64'(cmd.sa[4:0]) | (64'(cmd.sb[4:0]) << 5)
						| (64'(cmd.mode) << 10);
					wa_mem[cmd.slot] <= 64'(cmd.cnt);
					wb_mem[cmd.slot] <= 64'(cmd.sz);
					owner_mem[claim_ch] <= 7'(cmd.slot);
				end
				T_SEND: begin
					chan_mem[cmd.slot] <= rd_dchan_q;
					small_mem[cmd.slot] <= 64'(cmd.dpe) | (64'(cmd.didx) << 4)
						| (64'(cmd.dvpe) << 9) | (64'(cmd.sa) << 25) | (64'(cmd.sb) << 41);
					wa_mem[cmd.slot] <= cmd.wa;
					wb_mem[cmd.slot] <= '0;
				end
				T_MEM: begin
					chan_mem[cmd.slot] <= claim_ch;
					small_mem[cmd.slot] <= 64'(cmd.dpe) | (64'(cmd.dvpe) << 4)
						| (64'(cmd.mode) << 20);
					wa_mem[cmd.slot] <= cmd.wa;
					wb_mem[cmd.slot] <= cmd.wb;
					owner_mem[claim_ch] <= 7'(cmd.slot);
				end
				T_INVALID: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_EPS; i++) type_q[i] <= T_INVALID;
			for (int i = 0; i < NUM_PES; i++) begin
				vpe_q[i] <= '0;
				priv_q[i] <= '0;
			end
			in_use_q <= '0;
			out_valid <= 1'b0;
			rd_type_q <= T_INVALID;
			rd_dtype_q <= T_INVALID;
			walk_q <= '0;
			walk_ph_q <= 1'b0;
			res <= '0;
		end else begin
			out_valid <= load_res || (out_valid && out_stall);
			if (load_res) res <= res_n;
			unique case (state_q)
				ST_IDLE: if (!q_empty) state_q <= ST_READ;
				ST_READ: begin
					rd_type_q  <= type_q[cmd.slot];
					rd_dtype_q <= type_q[cmd.dslot];
					walk_q <= (EPI_W+1)'(cmd.ep);
					walk_ph_q <= 1'b0;
					state_q <= (!cmd.bad && cmd.func == F_INV_FROM) ? ST_WALK : ST_EXEC;
				end
				// per endpoint: a registered read, then a clear
				ST_WALK: begin
					if (walk_done) begin
						if (walk_fire) state_q <= ST_IDLE;
					end else if (!walk_ph_q) begin
						rd_type_q <= type_q[wslot];
						walk_ph_q <= 1'b1;
					end else begin
						if (rd_type_q == T_RECV || rd_type_q == T_MEM)
							in_use_q[rd_chan_q] <= 1'b0;
						type_q[wslot] <= T_INVALID;
						walk_q <= walk_q + (EPI_W+1)'(1);
						walk_ph_q <= 1'b0;
					end
				end
				ST_EXEC: if (exec_fire) begin
					state_q <= ST_IDLE;
					if (type_we) type_q[cmd.slot] <= type_wd;
					if (use_we) in_use_q[use_ch] <= use_set;
					if (!cmd.bad && cmd.func == F_SET_ID) vpe_q[cmd.pe] <= cmd.dvpe;
					if (!cmd.bad && cmd.func == F_SET_PRIV) priv_q[cmd.pe] <= cmd.mode;
				end
			endcase
		end
	end

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty queue");
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid) else $error("finished command without result");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> 32'(walk_q) <= EPS_PER_PE) else $error("walk overran");

endmodule

[design/endpoint_channel_table_top.sv]
// endpoint_channel_table_top: top level of the endpoint channel table
// depends on ect_pkg, ect_front, ect_queue, ect_back
//
// usage:
//   input channel (in_valid / in_stall) carries one control command per transaction;
//   output channel (out_valid / out_stall) returns one status transaction per command
//   the front checks ranges and computes receive ring geometry, then pushes
//   the classified command into a two-entry queue
//   the back moves from idle (noticing the queue head) to read (reading the endpoint
//   table) to exec (executing and writing back, loading the result register);
//   it finishes one command before it takes the next one from the queue
//   invalidate_from walks the endpoints of the element from ep_index upwards,
//   each with a registered read and then a clear, before its result is loaded
//   after reset all endpoints are invalid, all channels free, ids and privileges zero;
//   no clearing pass is needed, valid bits live in flip-flops
//   when the receiver stalls, the result register holds and the back waits;
//   the queue keeps accepting until it holds two commands, then in_stall rises
module endpoint_channel_table_top import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [2:0]  pe_sel,
	input  logic [3:0]  ep_index,
	input  logic [2:0]  dest_pe,
	input  logic [4:0]  dest_index,
	input  logic [15:0] dst_vpe_id,
	input  logic [15:0] size_a,
	input  logic [15:0] size_b,
	input  logic [7:0]  mode_bits,
	input  logic [63:0] wide_a,
	input  logic [63:0] wide_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [4:0]  channel_out,
	output logic [31:0] ring_slots,
	output logic [31:0] ring_slot_bytes,
	output logic [1:0]  wake_target
);

	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_in, q_head;
	res_t res;

	assign in_stall = q_full;

	// front: accept and classify
	ect_front u_front (
		.in_valid, .func, .pe_sel, .ep_index, .dest_pe, .dest_index,
		.dst_vpe_id, .size_a, .size_b, .mode_bits, .wide_a, .wide_b,
		.q_full, .q_push, .q_data(q_in)
	);

	// decoupling queue
	ect_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.full(q_full), .empty(q_empty), .head(q_head)
	);

	// back: table and channel pool
	ect_back u_back (
		.clk, .arst_n, .q_empty, .cmd(q_head), .q_pop, .out_valid, .out_stall, .res
	);

	assign status          = res.status;
	assign channel_out     = res.chan;
	assign ring_slots      = res.cnt;
	assign ring_slot_bytes = res.sz;
	assign wake_target     = res.wake;

endmodule
